// File: design/lpht_pkg.sv
package lpht_pkg;

	localparam int DEF_SLOTS        = 1024;
	localparam int DEF_VALUE_BITS   = 32;
	localparam int KEY_BITS         = 32;
	localparam int OUT_VALUE_BITS   = 32;
	localparam int ENTRY_COUNT_BITS = 11;
	localparam int MOD_DIGIT        = 4;

	localparam logic [31:0] GOLDEN_MUL = 32'd2654435761;

	localparam logic [2:0] REQ_PUT    = 3'd0;
	localparam logic [2:0] REQ_GET    = 3'd1;
	localparam logic [2:0] REQ_REMOVE = 3'd2;
	localparam logic [2:0] REQ_PEEK   = 3'd3;
	localparam logic [2:0] REQ_TAKE   = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic       clear;
		logic       load;
		logic       mix1;
		logic       mix2;
		logic       mul;
		logic       mod_step;
		logic       probe_home;
		logic       probe_zero;
		logic       probe_run;
		logic       commit;
		logic       finish;
		logic [1:0] fin_status;
	} lpht_cmd_t;

	typedef struct packed {
		logic is_put;
		logic is_lookup;
		logic is_first;
		logic full;
		logic empty;
		logic mod_last;
		logic hit;
		logic exhausted;
		logic clr_last;
	} lpht_stat_t;

endpackage

// File: design/lpht_ram.sv
module lpht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/lpht_ctrl.sv
module lpht_ctrl import lpht_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  lpht_stat_t stat,
	output lpht_cmd_t  cmd,
	output logic       busy
);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_DECODE = 4'd2;
	localparam logic [3:0] S_MIX1   = 4'd3;
	localparam logic [3:0] S_MIX2   = 4'd4;
	localparam logic [3:0] S_MUL    = 4'd5;
	localparam logic [3:0] S_MOD    = 4'd6;
	localparam logic [3:0] S_PROBE  = 4'd7;
	localparam logic [3:0] S_COMMIT = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.is_put) begin
					if (stat.full) begin
						cmd.finish     = 1'b1;
						cmd.fin_status = ST_FULL;
						state_d        = S_IDLE;
					end else begin
						state_d = S_MIX1;
					end
				end else if (stat.is_lookup) begin
					state_d = S_MIX1;
				end else if (stat.is_first && !stat.empty) begin
					cmd.probe_zero = 1'b1;
					state_d        = S_PROBE;
				end else begin
					cmd.finish     = 1'b1;
					cmd.fin_status = ST_MISSING;
					state_d        = S_IDLE;
				end
			end
			S_MIX1: begin
				cmd.mix1 = 1'b1;
				state_d  = S_MIX2;
			end
			S_MIX2: begin
				cmd.mix2 = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_MOD;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) begin
					cmd.probe_home = 1'b1;
					state_d        = S_PROBE;
				end
			end
			S_PROBE: begin
				cmd.probe_run = 1'b1;
				if (stat.hit) begin
					state_d = S_COMMIT;
				end else if (stat.exhausted) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = stat.is_put ? ST_FULL : ST_MISSING;
					state_d        = S_IDLE;
				end
			end
			S_COMMIT: begin
				cmd.commit     = 1'b1;
				cmd.finish     = 1'b1;
				cmd.fin_status = ST_OK;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: design/lpht_dp.sv
module lpht_dp import lpht_pkg::*; #(
	parameter int SLOTS      = DEF_SLOTS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lpht_cmd_t                   cmd,
	output lpht_stat_t                  stat,
	input  logic [2:0]                  req_type,
	input  logic [KEY_BITS-1:0]         key,
	input  logic [31:0]                 value,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [OUT_VALUE_BITS-1:0]   found_value,
	output logic [ENTRY_COUNT_BITS-1:0] entry_count
);

	localparam int  IW        = $clog2(SLOTS);
	localparam int  CW        = $clog2(SLOTS + 1);
	localparam int  RW        = IW + 1;
	localparam int  KVW       = KEY_BITS + VALUE_BITS;
	localparam bit  IS_POW2   = ((SLOTS & (SLOTS - 1)) == 0);
	localparam int  MOD_STEPS = KEY_BITS / MOD_DIGIT;
	localparam int  MSW       = $clog2(MOD_STEPS);

	function automatic logic [31:0] mix_a(input logic [31:0] k_in);
		logic [31:0] k;
		k = k_in;
		k = k + (k << 12);
		k = k ^ (k >> 22);
		k = k + (k << 4);
		k = k ^ (k >> 9);
		return k;
	endfunction

	function automatic logic [31:0] mix_b(input logic [31:0] k_in);
		logic [31:0] k;
		k = k_in;
		k = k + (k << 10);
		k = k ^ (k >> 2);
		k = k + (k << 7);
		k = k ^ (k >> 12);
		return k;
	endfunction

	logic [2:0]                req_q;
	logic [KEY_BITS-1:0]       key_q;
	logic [VALUE_BITS-1:0]     val_q;
	logic [31:0]               h_q;
	logic [31:0]               prod_q;
	logic [IW-1:0]             rem_q;
	logic [MSW-1:0]            mod_cnt_q;
	logic [IW-1:0]             rem_next;
	logic [IW-1:0]             home_next;
	logic [IW-1:0]             addr_q;
	logic [CW-1:0]             cnt_q;
	logic                      pend_s1;
	logic [IW-1:0]             addr_s1;
	logic [IW-1:0]             hit_addr_q;
	logic                      hit_valid_q;
	logic [OUT_VALUE_BITS-1:0] hit_val_q;
	logic [IW-1:0]             clr_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             count_new;
	logic                      done_q;
	logic [1:0]                status_q;
	logic [OUT_VALUE_BITS-1:0] found_value_q;
	logic [ENTRY_COUNT_BITS-1:0] entry_count_q;

	logic is_put, is_get, is_remove, is_peek, is_take;
	logic v_rd;
	logic [KVW-1:0] kv_rd;
	logic [KEY_BITS-1:0] k_rd;
	logic [VALUE_BITS-1:0] val_rd;
	logic cond, hit, issue;
	logic v_we, v_wdata, kv_we;
	logic [IW-1:0] v_waddr;

	assign is_put    = (req_q == REQ_PUT);
	assign is_get    = (req_q == REQ_GET);
	assign is_remove = (req_q == REQ_REMOVE);
	assign is_peek   = (req_q == REQ_PEEK);
	assign is_take   = (req_q == REQ_TAKE);

	always_comb begin
		logic [IW-1:0] rr;
		logic [RW-1:0] t;
		rr = rem_q;
		for (int j = 0; j < MOD_DIGIT; j++) begin
			t = {rr, prod_q[KEY_BITS-1-j]};
			if (t >= RW'(SLOTS)) begin
				t = t - RW'(SLOTS);
			end
			rr = t[IW-1:0];
		end
		rem_next = rr;
	end

	assign home_next = IS_POW2 ? prod_q[IW-1:0] : rem_next;

	assign k_rd   = kv_rd[KVW-1 -: KEY_BITS];
	assign val_rd = kv_rd[VALUE_BITS-1:0];

	always_comb begin
		if (is_put) begin
			cond = !v_rd || (k_rd == key_q);
		end else if (is_get || is_remove) begin
			cond = v_rd && (k_rd == key_q);
		end else begin
			cond = v_rd;
		end
	end

	assign hit   = pend_s1 && cond;
	assign issue = cmd.probe_run && (cnt_q != CW'(SLOTS));

	assign stat.is_put    = is_put;
	assign stat.is_lookup = is_get || is_remove;
	assign stat.is_first  = is_peek || is_take;
	assign stat.full      = (count_q == CW'(SLOTS));
	assign stat.empty     = (count_q == '0);
	assign stat.mod_last  = IS_POW2 || (mod_cnt_q == MSW'(MOD_STEPS - 1));
	assign stat.hit       = hit;
	assign stat.exhausted = !pend_s1 && (cnt_q == CW'(SLOTS));
	assign stat.clr_last  = (clr_q == IW'(SLOTS - 1));

	always_comb begin
		count_new = count_q;
		if (cmd.commit) begin
			if (is_put && !hit_valid_q) begin
				count_new = count_q + 1'b1;
			end else if (is_remove || is_take) begin
				count_new = count_q - 1'b1;
			end
		end
	end

	assign v_we    = cmd.clear || (cmd.commit && (is_put || is_remove || is_take));
	assign v_waddr = cmd.clear ? clr_q : hit_addr_q;
	assign v_wdata = !cmd.clear && is_put;
	assign kv_we   = cmd.commit && is_put;

	lpht_ram #(
		.WIDTH(1),
		.DEPTH(SLOTS)
	) u_valid_ram (
		.clk  (clk),
		.we   (v_we),
		.waddr(v_waddr),
		.wdata(v_wdata),
		.raddr(addr_q),
		.rdata(v_rd)
	);

	lpht_ram #(
		.WIDTH(KVW),
		.DEPTH(SLOTS)
	) u_kv_ram (
		.clk  (clk),
		.we   (kv_we),
		.waddr(hit_addr_q),
		.wdata({key_q, val_q}),
		.raddr(addr_q),
		.rdata(kv_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q     <= req_type;
			key_q     <= key;
			val_q     <= VALUE_BITS'(value);
			h_q       <= key;
			hit_val_q <= '0;
		end
		if (cmd.mix1) begin
			h_q <= mix_a(h_q);
		end
		if (cmd.mix2) begin
			h_q <= mix_b(h_q);
		end
		if (cmd.mul) begin
			prod_q    <= 32'((h_q >> 3) * GOLDEN_MUL);
			rem_q     <= '0;
			mod_cnt_q <= '0;
		end
		if (cmd.mod_step) begin
			prod_q    <= prod_q << MOD_DIGIT;
			rem_q     <= rem_next;
			mod_cnt_q <= mod_cnt_q + 1'b1;
		end
		if (cmd.probe_home || cmd.probe_zero) begin
			addr_q <= cmd.probe_home ? home_next : '0;
			cnt_q  <= '0;
		end else if (issue) begin
			addr_q <= (addr_q == IW'(SLOTS - 1)) ? '0 : addr_q + 1'b1;
			cnt_q  <= cnt_q + 1'b1;
		end
		addr_s1 <= addr_q;
		if (cmd.probe_run && hit) begin
			hit_addr_q  <= addr_s1;
			hit_valid_q <= v_rd;
			if (is_get || is_peek || is_take) begin
				hit_val_q <= OUT_VALUE_BITS'(val_rd);
			end
		end
		if (cmd.finish) begin
			status_q      <= cmd.fin_status;
			found_value_q <= hit_val_q;
			entry_count_q <= ENTRY_COUNT_BITS'(count_new);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			clr_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cmd.probe_home || cmd.probe_zero) begin
				pend_s1 <= 1'b0;
			end else begin
				pend_s1 <= issue;
			end
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			count_q <= count_new;
			done_q  <= cmd.finish;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found_value = found_value_q;
	assign entry_count = entry_count_q;

endmodule

// File: design/linear_probe_hash_table_unit.sv
// channel   direction  transfer                ports
// request   in         start && !busy          req_type, key, value
// result    out        done (one cycle)        status, found_value, entry_count
//
// Put, get, remove: decode, the two mix steps, the multiply and the digit-serial
// remainder (a single step when SLOTS is a power of two), then one probe per cycle
// with a registered read from the slot RAMs, then a commit when the slot is found.
// A get or remove of an absent key probes all SLOTS slots.
// Peek and take scan from slot 0 up to the first occupied slot.
// After reset the valid RAM is swept clear, slot by slot, with busy high.
// The result strobe cannot be stalled; busy is low again in the strobe cycle.
module linear_probe_hash_table_unit import lpht_pkg::*; #(
	parameter int SLOTS      = DEF_SLOTS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [2:0]                  req_type,
	input  logic [KEY_BITS-1:0]         key,
	input  logic [31:0]                 value,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [OUT_VALUE_BITS-1:0]   found_value,
	output logic [ENTRY_COUNT_BITS-1:0] entry_count
);

	lpht_cmd_t  cmd;
	lpht_stat_t stat;

	lpht_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	lpht_dp #(
		.SLOTS     (SLOTS),
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_type   (req_type),
		.key        (key),
		.value      (value),
		.done       (done),
		.status     (status),
		.found_value(found_value),
		.entry_count(entry_count)
	);

endmodule

// File: design/lpht_checker.sv
module lpht_checker import lpht_pkg::*; (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [1:0]                  status,
	input logic [OUT_VALUE_BITS-1:0]   found_value
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted request did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in progress");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_MISSING || status == ST_FULL))
		else $error("undefined status code");

	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> found_value == '0)
		else $error("found_value nonzero on failed request");

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (.*);

// File: sim/lpht_checker.sv
`timescale 1ns / 1ps

module lpht_tb_checker import lpht_pkg::*; #(
	parameter int SLOTS = DEF_SLOTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [2:0]                  req_type,
	input  logic [KEY_BITS-1:0]         key,
	input  logic [31:0]                 value,
	input  logic                        done,
	input  logic [1:0]                  status,
	input  logic [OUT_VALUE_BITS-1:0]   found_value,
	input  logic [ENTRY_COUNT_BITS-1:0] entry_count,
	output int                          fail_count,
	output int                          pending,
	output int                          table_count
);

	typedef struct packed {
		logic [1:0]                  st;
		logic [OUT_VALUE_BITS-1:0]   val;
		logic [ENTRY_COUNT_BITS-1:0] cnt;
	} reply_t;

	localparam logic [31:0] SLOT_COUNT = SLOTS;

	logic [KEY_BITS-1:0] slot_key [SLOTS];
	logic [31:0]         slot_val [SLOTS];
	bit                  slot_used [SLOTS];
	int                  used_count;
	reply_t              replies_due [$];
	reply_t              want;

	function automatic int home_of(logic [31:0] k);
		logic [31:0] h;
		h = k;
		h = h + (h << 12);
		h = h ^ (h >> 22);
		h = h + (h << 4);
		h = h ^ (h >> 9);
		h = h + (h << 10);
		h = h ^ (h >> 2);
		h = h + (h << 7);
		h = h ^ (h >> 12);
		h = (h >> 3) * GOLDEN_MUL;
		return int'(h % SLOT_COUNT);
	endfunction

	function automatic int locate(logic [31:0] k);
		int s;
		int i;
		int at;
		s = home_of(k);
		at = -1;
		for (i = 0; i < SLOTS; i++) begin
			if (slot_used[s] && slot_key[s] == k) begin
				at = s;
				break;
			end
			s = (s + 1) % SLOTS;
		end
		return at;
	endfunction

	function automatic reply_t apply_request(logic [2:0] req, logic [31:0] k, logic [31:0] v);
		reply_t r;
		int s;
		int i;
		r.st = ST_MISSING;
		r.val = '0;
		case (req)
			REQ_PUT: begin
				if (used_count >= SLOTS) begin
					r.st = ST_FULL;
				end else begin
					s = home_of(k);
					for (i = 0; i < SLOTS; i++) begin
						if (!slot_used[s] || slot_key[s] == k)
							break;
						s = (s + 1) % SLOTS;
					end
					if (i < SLOTS) begin
						if (!slot_used[s])
							used_count++;
						slot_used[s] = 1'b1;
						slot_key[s] = k;
						slot_val[s] = v;
						r.st = ST_OK;
					end else begin
						r.st = ST_FULL;
					end
				end
			end
			REQ_GET, REQ_REMOVE: begin
				s = locate(k);
				if (s >= 0) begin
					r.st = ST_OK;
					if (req == REQ_GET) begin
						r.val = slot_val[s];
					end else begin
						slot_used[s] = 1'b0;
						slot_key[s] = '0;
						slot_val[s] = '0;
						if (used_count > 0)
							used_count--;
					end
				end
			end
			REQ_PEEK, REQ_TAKE: begin
				if (used_count > 0) begin
					for (s = 0; s < SLOTS; s++) begin
						if (slot_used[s]) begin
							r.val = slot_val[s];
							r.st = ST_OK;
							if (req == REQ_TAKE) begin
								slot_used[s] = 1'b0;
								used_count--;
							end
							break;
						end
					end
				end
			end
			default: r.st = ST_MISSING;
		endcase
		r.cnt = used_count[ENTRY_COUNT_BITS-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (replies_due.size() == 0) begin
					if (fail_count < 10)
						$display({"%0t: result with nothing outstanding: ",
							"status %0d value %h count %0d"},
							$realtime, status, found_value, entry_count);
					fail_count++;
				end else begin
					want = replies_due.pop_front();
					if (status !== want.st || found_value !== want.val ||
							entry_count !== want.cnt) begin
						if (fail_count < 10)
							$display({"%0t: mismatch (expected/actual) ",
								"status %0d/%0d value %h/%h count %0d/%0d"},
								$realtime, want.st, status, want.val, found_value,
								want.cnt, entry_count);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				replies_due.push_back(apply_request(req_type, key, value));
			pending = replies_due.size();
			table_count = used_count;
		end
	end

endmodule

// File: sim/tb_linear_probe_hash_table_unit.sv
`timescale 1ns / 1ps

module tb_linear_probe_hash_table_unit import lpht_pkg::*;;

	localparam int SLOTS = DEF_SLOTS;
	localparam int POOL = 40;
	localparam int MIXED_ITEMS = 110;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE = 1100;
	localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REQ_SPARE_LAST = 3'd7;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic [2:0]                  req_type = REQ_PUT;
	logic [KEY_BITS-1:0]         key = '0;
	logic [31:0]                 value = '0;
	logic                        busy;
	logic                        done;
	logic [1:0]                  status;
	logic [OUT_VALUE_BITS-1:0]   found_value;
	logic [ENTRY_COUNT_BITS-1:0] entry_count;
	int                          fail_count;
	int                          pending;
	int                          table_count;
	int                          sent;
	int                          quiet;
	logic [31:0]                 key_pool [POOL];

	linear_probe_hash_table_unit #(
		.SLOTS(SLOTS),
		.VALUE_BITS(DEF_VALUE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.key(key),
		.value(value),
		.done(done),
		.status(status),
		.found_value(found_value),
		.entry_count(entry_count)
	);

	lpht_tb_checker #(.SLOTS(SLOTS)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.key(key),
		.value(value),
		.done(done),
		.status(status),
		.found_value(found_value),
		.entry_count(entry_count),
		.fail_count(fail_count),
		.pending(pending),
		.table_count(table_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic issue(input logic [2:0] req, input logic [31:0] k, input logic [31:0] v,
			input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		key <= k;
		value <= v;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic mixed_traffic(input int n, input int idle_pct);
		int i;
		int pick;
		logic [2:0] req;
		logic [31:0] k;
		for (i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 36)
				req = REQ_PUT;
			else if (pick < 60)
				req = REQ_GET;
			else if (pick < 76)
				req = REQ_REMOVE;
			else if (pick < 86)
				req = REQ_PEEK;
			else if (pick < 96)
				req = REQ_TAKE;
			else
				req = 3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST));
			if ($urandom_range(99) < 85)
				k = key_pool[$urandom_range(POOL - 1)];
			else
				k = $urandom;
			issue(req, k, $urandom, idle_pct);
		end
	endtask

	initial begin
		int i;
		logic [31:0] fill_base;
		logic [31:0] first_key;

		key_pool[0] = '0;
		key_pool[1] = '1;
		for (i = 2; i < POOL; i++)
			key_pool[i] = $urandom;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(REQ_PEEK, $urandom, $urandom, 0);
		issue(REQ_TAKE, $urandom, $urandom, 0);
		issue(REQ_GET, 32'h0000_0000, $urandom, 0);
		issue(REQ_REMOVE, 32'hFFFF_FFFF, $urandom, 0);
		issue(REQ_PUT, 32'h0000_0000, 32'h0000_0000, 0);
		issue(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		issue(REQ_PUT, 32'h0000_0000, 32'h5A5A_A5A5, 0);
		issue(REQ_GET, 32'h0000_0000, $urandom, 0);
		issue(REQ_GET, 32'hFFFF_FFFF, $urandom, 0);
		issue(REQ_PEEK, $urandom, $urandom, 0);
		issue(REQ_TAKE, $urandom, $urandom, 0);
		issue(REQ_PEEK, $urandom, $urandom, 0);
		issue(REQ_REMOVE, 32'hFFFF_FFFF, $urandom, 0);
		issue(REQ_REMOVE, 32'h0000_0000, $urandom, 0);
		issue(REQ_GET, 32'h0000_0000, $urandom, 0);
		issue(REQ_PUT, 32'h0000_0001, $urandom, 0);
		issue(REQ_REMOVE, 32'h0000_0001, $urandom, 0);
		issue(REQ_REMOVE, 32'h0000_0001, $urandom, 0);
		issue(REQ_SPARE_FIRST, $urandom, $urandom, 0);
		issue(REQ_SPARE_FIRST + 3'd1, $urandom, $urandom, 0);
		issue(REQ_SPARE_LAST, $urandom, $urandom, 0);
		issue(REQ_PUT, 32'h8000_0000, 32'h8000_0000, 0);
		issue(REQ_TAKE, $urandom, $urandom, 0);
		drain();

		mixed_traffic(MIXED_ITEMS, 0);
		drain();
		mixed_traffic(MIXED_ITEMS, 82);
		drain();
		mixed_traffic(MIXED_ITEMS, 16);
		drain();

		fill_base = $urandom;
		first_key = {fill_base[31:12], 12'd0};
		i = 0;
		while (table_count < SLOTS && i < 4 * SLOTS) begin
			issue(REQ_PUT, {fill_base[31:12], 12'(i)}, $urandom, 0);
			drain();
			i++;
		end

		issue(REQ_PUT, first_key, $urandom, 0);
		issue(REQ_PUT, $urandom, $urandom, 16);
		issue(REQ_GET, first_key, $urandom, 16);
		issue(REQ_GET, $urandom, $urandom, 16);
		issue(REQ_REMOVE, first_key, $urandom, 16);
		issue(REQ_PUT, $urandom, $urandom, 16);
		issue(REQ_TAKE, $urandom, $urandom, 16);
		issue(REQ_PEEK, $urandom, $urandom, 16);
		issue(REQ_PUT, first_key, $urandom, 16);
		drain();

		repeat (SETTLE) @(posedge clk);

		$display({"covered %0d requests: directed corners, three mixed phases, ",
			"a fill to %0d slots"}, sent, SLOTS);
		$display("mismatches counted: %0d", fail_count);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
